FILE: rtl/flcr_pkg.sv
// Package for the framed link command receiver.
// Holds framing constants, the event passed from front to back, and the CRC step.
// No dependencies.
`default_nettype none
package flcr_pkg;

  localparam int MAX_PAYLOAD = 32;

  localparam logic [7:0]  SYNC_A       = 8'hA5;
  localparam logic [7:0]  SYNC_B       = 8'h5A;
  localparam logic [7:0]  LINK_VER     = 8'h01;
  localparam logic [7:0]  KIND_COMMAND = 8'h10;
  localparam logic [15:0] CRC_POLY     = 16'h1021;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] WDOG_RESET   = 16'd500;
  localparam logic [15:0] SILENCE_MAX  = 16'hFFFF;

  localparam int HDR_BYTES = 12;
  localparam int IDX_VER   = 2;
  localparam int IDX_KIND  = 3;
  localparam int IDX_LEN_L = 4;
  localparam int IDX_LEN_H = 5;
  localparam int IDX_SEQ_L = 6;
  localparam int IDX_SEQ_H = 7;

  localparam int CNT_W = $clog2(HDR_BYTES + MAX_PAYLOAD + 2);
  localparam int POS_W = (CNT_W > 8) ? CNT_W : 8;

  localparam logic [7:0] CMD_STOP  = 8'd0;
  localparam logic [7:0] CMD_START = 8'd1;
  localparam logic [7:0] CMD_ESTOP = 8'd2;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_STOP  = 3'd1,
    ACT_START = 3'd2,
    ACT_ESTOP = 3'd3,
    ACT_WDOG  = 3'd4
  } action_t;

  typedef struct packed {
    logic        tick;
    logic        good;
    logic        bad;
    logic        cmd;
    logic [7:0]  kind;
    logic [7:0]  first;
    logic [15:0] seq;
  } event_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (r[15]) begin
        r = {r[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/flcr_front.sv
// Front end: accepts items, deframes bytes and checks the running CRC.
// Pushes one event per item into the queue. Uses flcr_pkg.
`default_nettype none
module flcr_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_mode,
  input  wire logic [7:0]        in_rx_byte,
  input  wire flcr_pkg::q_stat_t q_stat,
  output logic                   push,
  output flcr_pkg::event_t       push_ev
);

  localparam int CntW = flcr_pkg::CNT_W;
  localparam int PosW = flcr_pkg::POS_W;

  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [15:0]     crc_r, crc_nxt;
  logic [7:0]      ver_r, ver_nxt;
  logic [7:0]      kind_r, kind_nxt;
  logic [7:0]      len_r, len_nxt;
  logic            len_hi_nz_r, len_hi_nz_nxt;
  logic [15:0]     seq_r, seq_nxt;
  logic [7:0]      first_r, first_nxt;
  logic [7:0]      crc_lo_r, crc_lo_nxt;
  logic [PosW-1:0] pos;
  logic            in_fire;

  assign in_stall = q_stat.full;
  assign in_fire  = in_valid && !q_stat.full;
  assign push     = in_fire;
  assign pos      = PosW'(cnt_r) - PosW'(flcr_pkg::HDR_BYTES);

  always_comb begin
    cnt_nxt       = cnt_r;
    crc_nxt       = crc_r;
    ver_nxt       = ver_r;
    kind_nxt      = kind_r;
    len_nxt       = len_r;
    len_hi_nz_nxt = len_hi_nz_r;
    seq_nxt       = seq_r;
    first_nxt     = first_r;
    crc_lo_nxt    = crc_lo_r;
    push_ev.tick  = in_mode;
    push_ev.good  = 1'b0;
    push_ev.bad   = 1'b0;
    push_ev.cmd   = (kind_r == flcr_pkg::KIND_COMMAND) && (len_r >= 8'd2);
    push_ev.kind  = kind_r;
    push_ev.first = first_r;
    push_ev.seq   = seq_r;
    if (in_fire && !in_mode) begin
      if (cnt_r == '0) begin
        if (in_rx_byte == flcr_pkg::SYNC_A) begin
          cnt_nxt = CntW'(1);
          crc_nxt = flcr_pkg::CRC_INIT;
        end
      end else if (cnt_r == CntW'(1) && in_rx_byte != flcr_pkg::SYNC_B) begin
        if (in_rx_byte == flcr_pkg::SYNC_A) begin
          cnt_nxt = CntW'(1);
          crc_nxt = flcr_pkg::CRC_INIT;
        end else begin
          cnt_nxt = '0;
        end
      end else begin
        cnt_nxt = cnt_r + CntW'(1);
        if (cnt_r >= CntW'(2) && cnt_r < CntW'(flcr_pkg::HDR_BYTES)) begin
          crc_nxt = flcr_pkg::crc_step(crc_r, in_rx_byte);
          case (cnt_r)
            CntW'(flcr_pkg::IDX_VER):   ver_nxt = in_rx_byte;
            CntW'(flcr_pkg::IDX_KIND):  kind_nxt = in_rx_byte;
            CntW'(flcr_pkg::IDX_LEN_L): len_nxt = in_rx_byte;
            CntW'(flcr_pkg::IDX_LEN_H): len_hi_nz_nxt = (in_rx_byte != 8'd0);
            CntW'(flcr_pkg::IDX_SEQ_L): seq_nxt = {8'd0, in_rx_byte};
            CntW'(flcr_pkg::IDX_SEQ_H): seq_nxt = {in_rx_byte, seq_r[7:0]};
            default: ;
          endcase
          if (cnt_r == CntW'(flcr_pkg::HDR_BYTES - 1) &&
              (len_hi_nz_r || len_r > 8'(flcr_pkg::MAX_PAYLOAD))) begin
            cnt_nxt = '0;
          end
        end else if (cnt_r >= CntW'(flcr_pkg::HDR_BYTES)) begin
          if (pos < PosW'(len_r)) begin
            crc_nxt = flcr_pkg::crc_step(crc_r, in_rx_byte);
            if (pos == '0) begin
              first_nxt = in_rx_byte;
            end
          end else if (pos == PosW'(len_r)) begin
            crc_lo_nxt = in_rx_byte;
          end else begin
            cnt_nxt = '0;
            if (ver_r == flcr_pkg::LINK_VER && {in_rx_byte, crc_lo_r} == crc_r) begin
              push_ev.good = 1'b1;
            end else begin
              push_ev.bad = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      crc_r <= flcr_pkg::CRC_INIT;
    end else begin
      cnt_r <= cnt_nxt;
      crc_r <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ver_r       <= ver_nxt;
    kind_r      <= kind_nxt;
    len_r       <= len_nxt;
    len_hi_nz_r <= len_hi_nz_nxt;
    seq_r       <= seq_nxt;
    first_r     <= first_nxt;
    crc_lo_r    <= crc_lo_nxt;
  end

  a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(flcr_pkg::HDR_BYTES + flcr_pkg::MAX_PAYLOAD + 1))
    else $error("front byte counter out of range");

endmodule
`default_nettype wire

FILE: rtl/flcr_queue.sv
// Short event queue between front and back ends.
// Register array with read and write pointers. Uses flcr_pkg.
`default_nettype none
module flcr_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire flcr_pkg::event_t push_ev,
  input  wire logic             pop,
  output flcr_pkg::event_t      pop_ev,
  output flcr_pkg::q_stat_t     q_stat
);

  localparam int PtrW = flcr_pkg::QPTR_W;
  localparam int CntW = flcr_pkg::QCNT_W;

  flcr_pkg::event_t mem [flcr_pkg::QDEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign q_stat.full  = (cnt_r == CntW'(flcr_pkg::QDEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign pop_ev       = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + PtrW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + PtrW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_ev;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(flcr_pkg::QDEPTH))
    else $error("queue count above depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != CntW'(flcr_pkg::QDEPTH) && cnt_r != '0) |-> (wr_ptr_r != rd_ptr_r))
    else $error("queue pointers disagree with count");

endmodule
`default_nettype wire

FILE: rtl/flcr_back.sv
// Back end: session state, watchdog and the registered result stage.
// Pops events from the queue and holds the watchdog limit. Uses flcr_pkg.
`default_nettype none
module flcr_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [15:0]       cfg_wdata,
  input  wire flcr_pkg::q_stat_t q_stat,
  input  wire flcr_pkg::event_t  pop_ev,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [2:0]             out_action,
  output logic                   out_frame_good,
  output logic                   out_frame_bad,
  output logic [7:0]             out_frame_kind,
  output logic                   out_session_on,
  output logic                   out_timed_out,
  output logic [15:0]            out_command_sequence
);

  logic [15:0]       limit_r;
  logic              sess_r, sess_nxt;
  logic              tout_r, tout_nxt;
  logic [15:0]       cseq_r, cseq_nxt;
  logic [15:0]       silence_r, silence_nxt;
  logic              heard_r, heard_nxt;
  logic              out_valid_r, out_valid_nxt;
  flcr_pkg::action_t act_r, act_nxt;
  logic              good_r, bad_r;
  logic [7:0]        kind_r, kind_nxt;

  assign pop = !q_stat.empty && (!out_valid_r || !out_stall);

  always_comb begin
    sess_nxt    = sess_r;
    tout_nxt    = tout_r;
    cseq_nxt    = cseq_r;
    silence_nxt = silence_r;
    heard_nxt   = heard_r;
    act_nxt     = flcr_pkg::ACT_NONE;
    kind_nxt    = 8'd0;
    if (pop_ev.tick) begin
      if (silence_r != flcr_pkg::SILENCE_MAX) begin
        silence_nxt = silence_r + 16'd1;
      end
      if (sess_r && heard_r && silence_nxt > limit_r) begin
        sess_nxt = 1'b0;
        tout_nxt = 1'b1;
        act_nxt  = flcr_pkg::ACT_WDOG;
      end
    end else if (pop_ev.good) begin
      kind_nxt    = pop_ev.kind;
      silence_nxt = 16'd0;
      heard_nxt   = 1'b1;
      if (pop_ev.cmd) begin
        cseq_nxt = pop_ev.seq;
        unique case (pop_ev.first)
          flcr_pkg::CMD_STOP: begin
            sess_nxt = 1'b0;
            tout_nxt = 1'b0;
            act_nxt  = flcr_pkg::ACT_STOP;
          end
          flcr_pkg::CMD_START: begin
            sess_nxt = 1'b1;
            tout_nxt = 1'b0;
            act_nxt  = flcr_pkg::ACT_START;
          end
          flcr_pkg::CMD_ESTOP: begin
            sess_nxt = 1'b0;
            tout_nxt = 1'b0;
            act_nxt  = flcr_pkg::ACT_ESTOP;
          end
          default: ;
        endcase
      end
    end
    out_valid_nxt = pop ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= flcr_pkg::WDOG_RESET;
      sess_r      <= 1'b0;
      tout_r      <= 1'b0;
      cseq_r      <= 16'd0;
      silence_r   <= 16'd0;
      heard_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        sess_r    <= sess_nxt;
        tout_r    <= tout_nxt;
        cseq_r    <= cseq_nxt;
        silence_r <= silence_nxt;
        heard_r   <= heard_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      act_r  <= act_nxt;
      good_r <= pop_ev.good && !pop_ev.tick;
      bad_r  <= pop_ev.bad && !pop_ev.tick;
      kind_r <= kind_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_action           = act_r;
  assign out_frame_good       = good_r;
  assign out_frame_bad        = bad_r;
  assign out_frame_kind       = kind_r;
  assign out_session_on       = sess_r;
  assign out_timed_out        = tout_r;
  assign out_command_sequence = cseq_r;

  a_wdog_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && act_r == flcr_pkg::ACT_WDOG) |-> (tout_r && !sess_r))
    else $error("watchdog stop without timeout flag");

  a_good_bad_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(good_r && bad_r))
    else $error("frame reported both good and bad");

endmodule
`default_nettype wire

FILE: rtl/framed_link_command_receiver.sv
// Framed link command receiver, top level.
// Instantiates flcr_front, flcr_queue and flcr_back. Uses flcr_pkg.
//
// Input channel (in_valid / in_stall): each item is a UART byte (in_mode 0,
// in_rx_byte) or a one millisecond tick (in_mode 1). Frames are A5 5A, version,
// id, length, sequence, timestamp, payload and CRC-16/CCITT-FALSE; the CRC is
// updated per byte as it arrives.
// Result channel (out_valid / out_stall): one result per item, in order:
// action, frame good/bad pulses, frame id, session and timeout flags and the
// last command sequence.
// Configuration: cfg_we writes cfg_wdata to the watchdog limit (ms).
// Throughput: one item per cycle while in_stall is low. An accepted item is
// stored in the four-entry event queue, then popped into the output register.
// Reset: hunting for a sync byte, no session, limit 500 ms, queue empty.
// When the receiver stalls, the result holds in the output register, events
// collect in the queue, and in_stall rises once the queue is full.
`default_nettype none
module framed_link_command_receiver (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_mode,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_action,
  output logic             out_frame_good,
  output logic             out_frame_bad,
  output logic [7:0]       out_frame_kind,
  output logic             out_session_on,
  output logic             out_timed_out,
  output logic [15:0]      out_command_sequence,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);

  flcr_pkg::q_stat_t q_stat;
  flcr_pkg::event_t  push_ev;
  flcr_pkg::event_t  pop_ev;
  logic              push;
  logic              pop;

  flcr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_mode    (in_mode),
    .in_rx_byte (in_rx_byte),
    .q_stat     (q_stat),
    .push       (push),
    .push_ev    (push_ev)
  );

  flcr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_ev (push_ev),
    .pop     (pop),
    .pop_ev  (pop_ev),
    .q_stat  (q_stat)
  );

  flcr_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .q_stat               (q_stat),
    .pop_ev               (pop_ev),
    .pop                  (pop),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_action           (out_action),
    .out_frame_good       (out_frame_good),
    .out_frame_bad        (out_frame_bad),
    .out_frame_kind       (out_frame_kind),
    .out_session_on       (out_session_on),
    .out_timed_out        (out_timed_out),
    .out_command_sequence (out_command_sequence)
  );

endmodule
`default_nettype wire

FILE: dv/framed_link_command_receiver_tb.sv
// Testbench for framed_link_command_receiver: deframing, CRC, command actions and watchdog.
// Self-checking against an in-file predictor; depends on flcr_pkg and the RTL only.
`timescale 1ns / 1ps
module framed_link_command_receiver_tb;

  localparam int STUCK_LIMIT = 2000;

  typedef struct packed {
    flcr_pkg::action_t act;
    logic              good;
    logic              bad;
    logic [7:0]        kind;
    logic              sess;
    logic              tmo;
    logic [15:0]       seq;
  } link_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_mode = 1'b0;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_action;
  logic        out_frame_good;
  logic        out_frame_bad;
  logic [7:0]  out_frame_kind;
  logic        out_session_on;
  logic        out_timed_out;
  logic [15:0] out_command_sequence;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = 16'h0000;

  framed_link_command_receiver DUT (.*);

  always #5 clk = ~clk;

  // predictor state
  logic [15:0] lim_ms;
  int unsigned pos_cnt;
  logic [15:0] crc_acc;
  logic [7:0]  ver_q;
  logic [7:0]  kind_q;
  logic [15:0] len_q;
  logic [15:0] seq_q;
  logic [7:0]  first_q;
  logic [7:0]  crc_lo_q;
  logic        sess_q;
  logic        tmo_q;
  logic [15:0] cmd_seq_q;
  logic [15:0] quiet_ms;
  logic        heard_q;

  link_result_t pending_results[$];
  link_result_t seen_res;
  link_result_t want_res;
  int errors = 0;
  int items_sent = 0;
  int burst_left = 5;
  int stall_left = 0;
  int stuck_cycles = 0;
  bit no_idle = 1'b0;

  function automatic logic [15:0] crc16_next(logic [15:0] c, logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = {c[14:0], 1'b0};
      if (fb) c = c ^ flcr_pkg::CRC_POLY;
    end
    return c;
  endfunction

  function automatic void reset_link_model();
    lim_ms = flcr_pkg::WDOG_RESET;
    pos_cnt = 0;
    crc_acc = flcr_pkg::CRC_INIT;
    ver_q = 8'h00;
    kind_q = 8'h00;
    len_q = 16'h0000;
    seq_q = 16'h0000;
    first_q = 8'h00;
    crc_lo_q = 8'h00;
    sess_q = 1'b0;
    tmo_q = 1'b0;
    cmd_seq_q = 16'h0000;
    quiet_ms = 16'h0000;
    heard_q = 1'b0;
  endfunction

  function automatic link_result_t step_link(bit tick, logic [7:0] b);
    link_result_t r;
    int unsigned idx;
    int unsigned pos;
    logic [15:0] got_crc;
    r.act = flcr_pkg::ACT_NONE;
    r.good = 1'b0;
    r.bad = 1'b0;
    r.kind = 8'h00;
    if (tick) begin
      if (quiet_ms != flcr_pkg::SILENCE_MAX) quiet_ms++;
      if (sess_q && heard_q && quiet_ms > lim_ms) begin
        sess_q = 1'b0;
        tmo_q = 1'b1;
        r.act = flcr_pkg::ACT_WDOG;
      end
    end else begin
      idx = pos_cnt;
      if (idx == 0) begin
        if (b == flcr_pkg::SYNC_A) begin
          pos_cnt = 1;
          crc_acc = flcr_pkg::CRC_INIT;
        end
      end else if (idx == 1 && b != flcr_pkg::SYNC_B) begin
        if (b == flcr_pkg::SYNC_A) begin
          pos_cnt = 1;
          crc_acc = flcr_pkg::CRC_INIT;
        end else begin
          pos_cnt = 0;
        end
      end else begin
        pos_cnt = idx + 1;
        if (idx >= 2 && idx < flcr_pkg::HDR_BYTES) begin
          crc_acc = crc16_next(crc_acc, b);
          case (idx)
            flcr_pkg::IDX_VER:   ver_q = b;
            flcr_pkg::IDX_KIND:  kind_q = b;
            flcr_pkg::IDX_LEN_L: len_q = {8'h00, b};
            flcr_pkg::IDX_LEN_H: len_q[15:8] = b;
            flcr_pkg::IDX_SEQ_L: seq_q = {8'h00, b};
            flcr_pkg::IDX_SEQ_H: seq_q[15:8] = b;
            default: ;
          endcase
          if (idx == flcr_pkg::HDR_BYTES - 1 && len_q > flcr_pkg::MAX_PAYLOAD) pos_cnt = 0;
        end else if (idx >= flcr_pkg::HDR_BYTES) begin
          pos = idx - flcr_pkg::HDR_BYTES;
          if (pos < len_q) begin
            crc_acc = crc16_next(crc_acc, b);
            if (pos == 0) first_q = b;
          end else if (pos == len_q) begin
            crc_lo_q = b;
          end else begin
            got_crc = {b, crc_lo_q};
            pos_cnt = 0;
            if (ver_q != flcr_pkg::LINK_VER || got_crc != crc_acc) begin
              r.bad = 1'b1;
            end else begin
              r.good = 1'b1;
              r.kind = kind_q;
              quiet_ms = 16'h0000;
              heard_q = 1'b1;
              if (kind_q == flcr_pkg::KIND_COMMAND && len_q >= 2) begin
                cmd_seq_q = seq_q;
                if (first_q == flcr_pkg::CMD_STOP) begin
                  sess_q = 1'b0;
                  tmo_q = 1'b0;
                  r.act = flcr_pkg::ACT_STOP;
                end else if (first_q == flcr_pkg::CMD_START) begin
                  tmo_q = 1'b0;
                  sess_q = 1'b1;
                  r.act = flcr_pkg::ACT_START;
                end else if (first_q == flcr_pkg::CMD_ESTOP) begin
                  sess_q = 1'b0;
                  tmo_q = 1'b0;
                  r.act = flcr_pkg::ACT_ESTOP;
                end
              end
            end
          end
        end
      end
    end
    r.sess = sess_q;
    r.tmo = tmo_q;
    r.seq = cmd_seq_q;
    return r;
  endfunction

  task automatic send_item(input bit tick, input logic [7:0] b);
    in_valid <= 1'b1;
    in_mode <= tick;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(step_link(tick, b));
    items_sent++;
    if (!no_idle) begin
      burst_left--;
      if (burst_left <= 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        burst_left = $urandom_range(1, 24);
      end
    end
  endtask

  task automatic drive_frame(input logic [7:0] ver, input logic [7:0] kind,
                             input logic [15:0] len, input logic [15:0] seq,
                             input logic [7:0] first, input logic [15:0] crc_flip,
                             input int tick_pct, input int cut);
    logic [7:0] fb[$];
    logic [15:0] c;
    int n;
    fb = {};
    n = (len <= flcr_pkg::MAX_PAYLOAD) ? int'(len) : 3;
    fb.push_back(flcr_pkg::SYNC_A);
    fb.push_back(flcr_pkg::SYNC_B);
    fb.push_back(ver);
    fb.push_back(kind);
    fb.push_back(len[7:0]);
    fb.push_back(len[15:8]);
    fb.push_back(seq[7:0]);
    fb.push_back(seq[15:8]);
    repeat (4) fb.push_back(8'($urandom));
    for (int i = 0; i < n; i++) fb.push_back((i == 0) ? first : 8'($urandom));
    c = flcr_pkg::CRC_INIT;
    for (int i = 2; i < fb.size(); i++) c = crc16_next(c, fb[i]);
    c = c ^ crc_flip;
    fb.push_back(c[7:0]);
    fb.push_back(c[15:8]);
    if (cut > 0 && cut < fb.size()) fb = fb[0:cut-1];
    foreach (fb[i]) begin
      if ($urandom_range(0, 99) < tick_pct) send_item(1'b1, 8'($urandom));
      send_item(1'b0, fb[i]);
    end
  endtask

  task automatic settle_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_watchdog_limit(input logic [15:0] v);
    settle_results();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    lim_ms = v;
  endtask

  task automatic test_idle_noise();
    send_item(1'b1, 8'h00);
    send_item(1'b1, 8'hFF);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, flcr_pkg::SYNC_B);
  endtask

  task automatic test_sync_hunt();
    send_item(1'b0, flcr_pkg::SYNC_A);
    send_item(1'b0, 8'h00);
    send_item(1'b0, flcr_pkg::SYNC_A);
    drive_frame(flcr_pkg::LINK_VER, 8'h22, 16'd1, 16'h1234, 8'h55, 16'h0000, 0, 0);
    drive_frame(flcr_pkg::LINK_VER, flcr_pkg::KIND_COMMAND, 16'd2, 16'h0101,
                flcr_pkg::CMD_START, 16'h0000, 0, 7);
    drive_frame(flcr_pkg::LINK_VER, flcr_pkg::KIND_COMMAND, 16'd2, 16'h0202,
                flcr_pkg::CMD_START, 16'h0000, 30, 0);
  endtask

  task automatic test_command_codes();
    write_watchdog_limit(16'hFFFF);
    drive_frame(flcr_pkg::LINK_VER, flcr_pkg::KIND_COMMAND, 16'd2, 16'h0000,
                flcr_pkg::CMD_START, 16'h0000, 0, 0);
    drive_frame(flcr_pkg::LINK_VER, flcr_pkg::KIND_COMMAND, 16'(flcr_pkg::MAX_PAYLOAD),
                16'hFFFF, flcr_pkg::CMD_STOP, 16'h0000, 0, 0);
    drive_frame(flcr_pkg::LINK_VER, flcr_pkg::KIND_COMMAND, 16'd2, 16'h0003, 8'h03,
                16'h0000, 0, 0);
    drive_frame(flcr_pkg::LINK_VER, flcr_pkg::KIND_COMMAND, 16'd3, 16'h00FF, 8'hFF,
                16'h0000, 0, 0);
    drive_frame(flcr_pkg::LINK_VER, flcr_pkg::KIND_COMMAND, 16'd1, 16'h0777,
                flcr_pkg::CMD_START, 16'h0000, 0, 0);
    drive_frame(flcr_pkg::LINK_VER, flcr_pkg::KIND_COMMAND, 16'd0, 16'h0888,
                flcr_pkg::CMD_START, 16'h0000, 0, 0);
    drive_frame(flcr_pkg::LINK_VER, 8'hFF, 16'd3, 16'h0999, flcr_pkg::CMD_START,
                16'h0000, 0, 0);
    drive_frame(flcr_pkg::LINK_VER, 8'h00, 16'd2, 16'h0AAA, flcr_pkg::CMD_START,
                16'h0000, 0, 0);
    drive_frame(flcr_pkg::LINK_VER, flcr_pkg::KIND_COMMAND, 16'd2, 16'h8000,
                flcr_pkg::CMD_START, 16'h0000, 0, 0);
    drive_frame(flcr_pkg::LINK_VER, flcr_pkg::KIND_COMMAND, 16'd4, 16'h4321,
                flcr_pkg::CMD_ESTOP, 16'h0000, 0, 0);
  endtask

  task automatic test_frame_errors();
    drive_frame(flcr_pkg::LINK_VER, flcr_pkg::KIND_COMMAND, 16'd2, 16'h1111,
                flcr_pkg::CMD_START, 16'h0000, 0, 0);
    drive_frame(8'h00, flcr_pkg::KIND_COMMAND, 16'd2, 16'h2222, flcr_pkg::CMD_STOP,
                16'h0000, 0, 0);
    drive_frame(8'hFF, flcr_pkg::KIND_COMMAND, 16'd2, 16'h2223, flcr_pkg::CMD_STOP,
                16'h0000, 0, 0);
    drive_frame(flcr_pkg::LINK_VER, flcr_pkg::KIND_COMMAND, 16'd2, 16'h3333,
                flcr_pkg::CMD_STOP, 16'h0001, 0, 0);
    drive_frame(flcr_pkg::LINK_VER, flcr_pkg::KIND_COMMAND, 16'd2, 16'h3334,
                flcr_pkg::CMD_STOP, 16'h8000, 0, 0);
    drive_frame(flcr_pkg::LINK_VER, flcr_pkg::KIND_COMMAND, 16'(flcr_pkg::MAX_PAYLOAD + 1),
                16'h4444, flcr_pkg::CMD_STOP, 16'h0000, 0, 0);
    drive_frame(flcr_pkg::LINK_VER, flcr_pkg::KIND_COMMAND, 16'h0100, 16'h4445,
                flcr_pkg::CMD_STOP, 16'h0000, 0, 0);
    drive_frame(flcr_pkg::LINK_VER, flcr_pkg::KIND_COMMAND, 16'hFFFF, 16'h4446,
                flcr_pkg::CMD_STOP, 16'h0000, 0, 0);
    drive_frame(flcr_pkg::LINK_VER, flcr_pkg::KIND_COMMAND, 16'd2, 16'h5555,
                flcr_pkg::CMD_STOP, 16'h0000, 0, 0);
  endtask

  task automatic test_watchdog_trip();
    write_watchdog_limit(16'd1);
    drive_frame(flcr_pkg::LINK_VER, flcr_pkg::KIND_COMMAND, 16'd2, 16'h0010,
                flcr_pkg::CMD_START, 16'h0000, 0, 0);
    repeat (4) send_item(1'b1, 8'($urandom));
    drive_frame(flcr_pkg::LINK_VER, flcr_pkg::KIND_COMMAND, 16'd2, 16'h0011,
                flcr_pkg::CMD_START, 16'h0000, 0, 0);
    send_item(1'b1, 8'h00);
    drive_frame(flcr_pkg::LINK_VER, 8'h42, 16'd0, 16'h0012, 8'h00, 16'h0000, 0, 0);
    repeat (3) send_item(1'b1, 8'h00);
    write_watchdog_limit(16'd3);
    drive_frame(flcr_pkg::LINK_VER, flcr_pkg::KIND_COMMAND, 16'd2, 16'h0013,
                flcr_pkg::CMD_START, 16'h0000, 50, 0);
    repeat (5) send_item(1'b1, 8'h00);
  endtask

  task automatic test_random_traffic();
    int stop_at;
    int pick;
    int round;
    logic [7:0] ver;
    logic [7:0] kind;
    logic [7:0] first;
    logic [15:0] len;
    logic [15:0] seq;
    stop_at = items_sent + 120;
    round = 0;
    while (items_sent < stop_at) begin
      round++;
      if (round % 15 == 0) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) write_watchdog_limit(16'hFFFF);
        else if (pick == 1) write_watchdog_limit(16'd1);
        else write_watchdog_limit(16'($urandom_range(1, 40)));
        no_idle = ($urandom_range(0, 3) == 0);
      end
      kind = ($urandom_range(0, 9) < 6) ? flcr_pkg::KIND_COMMAND : 8'($urandom);
      len = ($urandom_range(0, 19) == 0) ? 16'(flcr_pkg::MAX_PAYLOAD) :
                                           16'($urandom_range(0, 6));
      first = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
      seq = 16'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 68) begin
        drive_frame(flcr_pkg::LINK_VER, kind, len, seq, first, 16'h0000, 10, 0);
      end else if (pick < 73) begin
        ver = 8'($urandom);
        if (ver == flcr_pkg::LINK_VER) ver = 8'h00;
        drive_frame(ver, kind, len, seq, first, 16'h0000, 10, 0);
      end else if (pick < 78) begin
        drive_frame(flcr_pkg::LINK_VER, kind, len, seq, first,
                    16'($urandom_range(1, 16'hFFFF)), 10, 0);
      end else if (pick < 82) begin
        drive_frame(flcr_pkg::LINK_VER, kind,
                    16'($urandom_range(flcr_pkg::MAX_PAYLOAD + 1, 16'hFFFF)), seq,
                    first, 16'h0000, 10, 0);
      end else if (pick < 85) begin
        drive_frame(flcr_pkg::LINK_VER, kind, len, seq, first, 16'h0000, 10,
                    $urandom_range(1, 15));
      end else if (pick < 94) begin
        repeat ($urandom_range(1, 30)) send_item(1'b1, 8'($urandom));
      end else begin
        repeat ($urandom_range(1, 8)) send_item(1'b0, 8'($urandom));
      end
    end
    no_idle = 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst_n || no_idle) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else begin
      out_stall <= !out_stall;
      stall_left = out_stall ? $urandom_range(2, 14) : $urandom_range(0, 5);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_res.act = flcr_pkg::action_t'(out_action);
      seen_res.good = out_frame_good;
      seen_res.bad = out_frame_bad;
      seen_res.kind = out_frame_kind;
      seen_res.sess = out_session_on;
      seen_res.tmo = out_timed_out;
      seen_res.seq = out_command_sequence;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: %p", seen_res);
      end else begin
        want_res = pending_results.pop_front();
        if (seen_res !== want_res) begin
          errors++;
          if (errors <= 10) begin
            $display({"mismatch: expected act=%0d good=%0b bad=%0b kind=%02h",
                      " sess=%0b tmo=%0b seq=%04h"},
                     want_res.act, want_res.good, want_res.bad, want_res.kind,
                     want_res.sess, want_res.tmo, want_res.seq);
            $display({"          actual   act=%0d good=%0b bad=%0b kind=%02h",
                      " sess=%0b tmo=%0b seq=%04h"},
                     seen_res.act, seen_res.good, seen_res.bad, seen_res.kind,
                     seen_res.sess, seen_res.tmo, seen_res.seq);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    reset_link_model();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_noise();
    test_sync_hunt();
    test_command_codes();
    test_frame_errors();
    test_watchdog_trip();
    test_random_traffic();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
